@@ rtl/qpc_pkg.sv @@
// Package: shared widths, register indexes, reset values and types for the position counter.
`timescale 1ns / 1ps
package qpc_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int POS_W             = 14;
  localparam int MAX_W             = 15;
  localparam int FLT_W             = 4;
  localparam int CFG_IDX_W         = 2;

  localparam logic [MAX_W-1:0] POS_LIMIT     = 15'd16384;
  localparam logic [MAX_W-1:0] MAX_VALUE_RST = 15'd16384;
  localparam logic [FLT_W-1:0] FILTER_RST    = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LENGTH = 2'd1;

  // filtered line: level before and after the current sample
  typedef struct packed {
    logic level;
    logic level_nxt;
  } flt_t;

endpackage

@@ rtl/qpc_if.sv @@
// Interfaces: valid/ready channels for encoder samples and position results.
`timescale 1ns / 1ps
interface qpc_in_if;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic                    line_a;
  logic                    line_b;
  logic [qpc_pkg::POS_W-1:0] load_value;

  modport source (output valid, cmd, line_a, line_b, load_value, input ready);
  modport sink   (input valid, cmd, line_a, line_b, load_value, output ready);
endinterface

interface qpc_out_if;
  logic                    valid;
  logic                    ready;
  logic [qpc_pkg::POS_W-1:0] position;
  logic                    changed;
  logic                    counting_down;

  modport source (output valid, position, changed, counting_down, input ready);
  modport sink   (input valid, position, changed, counting_down, output ready);
endinterface

@@ rtl/qpc_debounce.sv @@
// Debounce filter for one encoder line: level follows raw after N differing samples.
`timescale 1ns / 1ps
module qpc_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       raw,
  input  logic [qpc_pkg::FLT_W-1:0]  filter_length,
  output qpc_pkg::flt_t              st
);

  logic                      level_r, level_nxt;
  logic [qpc_pkg::FLT_W-1:0] count_r, count_nxt;
  logic [qpc_pkg::FLT_W-1:0] need;
  logic [qpc_pkg::FLT_W-1:0] count_inc;

  assign need      = (filter_length == '0) ? qpc_pkg::FLT_W'(1) : filter_length;
  assign count_inc = count_r + qpc_pkg::FLT_W'(1);

  always_comb begin
    level_nxt = level_r;
    count_nxt = count_r;
    if (en) begin
      if (raw == level_r) begin
        count_nxt = '0;
      end else if (count_inc >= need) begin
        level_nxt = raw;
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      count_r <= '0;
    end else begin
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
  end

  assign st.level     = level_r;
  assign st.level_nxt = level_nxt;

endmodule

@@ rtl/quadrature_position_counter_core.sv @@
// Top level: x4 quadrature position counter with debounced lines and load command.
`timescale 1ns / 1ps
// One beat is accepted every clock cycle unless the sink holds off; each
// result passes the input register, then the result register. The whole
// state update - both debounce filters, the up/down edge counter, the divide
// by four and the wrap against max_value - is one combinational pass from the
// state registers back into themselves, so there are no bubbles. The result
// register lets a new beat in while the previous result waits. The user must
// write configuration (index 0 max_value, index 1 filter_length) only while
// the block is idle; the block does not enforce it. Reset runs no clearing pass.
module quadrature_position_counter_core #(
  parameter int COUNTER_WIDTH = qpc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  qpc_in_if.sink                        in_ch,
  qpc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [qpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qpc_pkg::MAX_W-1:0]     cfg_wdata
);

  localparam int QW   = COUNTER_WIDTH - 2;
  localparam int CmpW = (QW > qpc_pkg::MAX_W) ? QW : qpc_pkg::MAX_W;

  // configuration
  logic [qpc_pkg::MAX_W-1:0] max_value_r;
  logic [qpc_pkg::FLT_W-1:0] filter_length_r;
  logic [qpc_pkg::MAX_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r     <= qpc_pkg::MAX_VALUE_RST;
      filter_length_r <= qpc_pkg::FILTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qpc_pkg::CFG_MAX_VALUE:     max_value_r     <= cfg_wdata;
        qpc_pkg::CFG_FILTER_LENGTH: filter_length_r <= cfg_wdata[qpc_pkg::FLT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = (max_value_r > qpc_pkg::POS_LIMIT) ? qpc_pkg::POS_LIMIT : max_value_r;

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic s1_fire;
  logic in_fire;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // input register
  logic                      s1_cmd_r;
  logic                      s1_a_r;
  logic                      s1_b_r;
  logic [qpc_pkg::POS_W-1:0] s1_load_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_a_r    <= in_ch.line_a;
      s1_b_r    <= in_ch.line_b;
      s1_load_r <= in_ch.load_value;
    end
  end

  // filters advance on sample beats only
  qpc_pkg::flt_t flt_a, flt_b;
  logic          sample_en;

  assign sample_en = s1_fire && !s1_cmd_r;

  qpc_debounce u_deb_a (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (sample_en),
    .raw           (s1_a_r),
    .filter_length (filter_length_r),
    .st            (flt_a)
  );

  qpc_debounce u_deb_b (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (sample_en),
    .raw           (s1_b_r),
    .filter_length (filter_length_r),
    .st            (flt_b)
  );

  // counter state
  logic [COUNTER_WIDTH-1:0]  counter_r, counter_nxt;
  logic [qpc_pkg::POS_W-1:0] held_r, held_nxt;
  logic                      down_r, down_nxt;

  logic [COUNTER_WIDTH-1:0]  cnt_step;
  logic [qpc_pkg::POS_W-1:0] held_pre;
  logic [CmpW-1:0]           quot_ext;
  logic [qpc_pkg::POS_W+1:0] load_x4;
  logic                      ch_a, ch_b, step_up;

  assign ch_a    = flt_a.level_nxt != flt_a.level;
  assign ch_b    = flt_b.level_nxt != flt_b.level;
  assign step_up = ch_a ? (flt_a.level_nxt != flt_b.level_nxt)
                        : (flt_a.level_nxt == flt_b.level_nxt);
  assign load_x4 = {s1_load_r, 2'b00};

  always_comb begin
    cnt_step = counter_r;
    held_pre = held_r;
    down_nxt = down_r;
    if (s1_cmd_r) begin
      held_pre = s1_load_r;
      cnt_step = COUNTER_WIDTH'(load_x4);
    end else if (ch_a != ch_b) begin
      if (step_up) begin
        cnt_step = counter_r + COUNTER_WIDTH'(1);
        down_nxt = 1'b0;
      end else begin
        cnt_step = counter_r - COUNTER_WIDTH'(1);
        down_nxt = 1'b1;
      end
    end
    quot_ext = CmpW'(cnt_step >> 2);

    // clamp at zero going down, wrap at the limit
    if (held_pre == '0 && down_nxt) begin
      counter_nxt = '0;
      held_nxt    = held_pre;
    end else if (quot_ext >= CmpW'(limit)) begin
      counter_nxt = '0;
      held_nxt    = '0;
    end else begin
      counter_nxt = cnt_step;
      held_nxt    = quot_ext[qpc_pkg::POS_W-1:0];
    end
    if (CmpW'(held_nxt) >= CmpW'(limit)) begin
      counter_nxt = '0;
      held_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      held_r    <= '0;
      down_r    <= 1'b0;
    end else if (s1_fire) begin
      counter_r <= counter_nxt;
      held_r    <= held_nxt;
      down_r    <= down_nxt;
    end
  end

  // result register
  logic [qpc_pkg::POS_W-1:0] out_pos_r;
  logic                      out_changed_r;
  logic                      out_down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pos_r     <= held_nxt;
      out_changed_r <= counter_nxt != counter_r;
      out_down_r    <= down_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.changed       = out_changed_r;
  assign out_ch.counting_down = out_down_r;

  // checks
  logic [CmpW-1:0] quot_r_ext;
  assign quot_r_ext = CmpW'(counter_r >> 2);

  // held position always tracks the counter divided by four
  a_held_tracks_counter: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == quot_r_ext[qpc_pkg::POS_W-1:0])
    else $error("held position out of step with edge counter");

  // result beat carries the state left by the beat that produced it
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_ch.position == held_r && out_ch.counting_down == down_r))
    else $error("result beat does not match counter state");

  // input stalls only when both stages are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without backpressure");

  // state moves only on a processed beat
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> ($stable(counter_r) && $stable(down_r)))
    else $error("counter state changed without a beat");

endmodule

@@ sim/quadrature_position_counter_core_test.sv @@
// Testbench: random and directed encoder traffic against a cycle-free position predictor.
`timescale 1ns / 1ps
module quadrature_position_counter_core_test;

  localparam int CNT_W = qpc_pkg::COUNTER_WIDTH_DEF;
  localparam int POS_W = qpc_pkg::POS_W;
  localparam int FLT_W = qpc_pkg::FLT_W;
  localparam int MAX_W = qpc_pkg::MAX_W;
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;
  localparam int POS_MAX = (1 << POS_W) - 1;

  typedef struct packed {
    logic             cmd;
    logic             line_a;
    logic             line_b;
    logic [POS_W-1:0] load_value;
  } sample_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             changed;
    logic             counting_down;
  } pos_result_t;

  typedef struct packed {
    logic             level;
    logic [FLT_W-1:0] run;
  } line_filt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [qpc_pkg::CFG_IDX_W-1:0] cfg_index = qpc_pkg::CFG_MAX_VALUE;
  logic [MAX_W-1:0] cfg_wdata = '0;

  qpc_in_if  in_ch ();
  qpc_out_if out_ch ();

  sample_t drv_item = '0;
  logic drv_valid = 1'b0;
  logic res_ready = 1'b0;

  assign in_ch.valid      = drv_valid;
  assign in_ch.cmd        = drv_item.cmd;
  assign in_ch.line_a     = drv_item.line_a;
  assign in_ch.line_b     = drv_item.line_b;
  assign in_ch.load_value = drv_item.load_value;
  assign out_ch.ready     = res_ready;

  quadrature_position_counter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sample_t     pending_q[$];
  pos_result_t expected_q[$];
  int          errors = 0;
  bit          steady = 1'b0;

  // register mirror
  logic [MAX_W-1:0] lim_reg = qpc_pkg::MAX_VALUE_RST;
  logic [FLT_W-1:0] flt_reg = qpc_pkg::FILTER_RST;

  // predictor state
  line_filt_t       filt_a = '0;
  line_filt_t       filt_b = '0;
  logic [CNT_W-1:0] edge_cnt = '0;
  logic [CNT_W-1:0] last_cnt = '0;
  logic [POS_W-1:0] held_pos = '0;
  logic             moving_down = 1'b0;

  // stimulus generator state: quadrature phase 0..3 = AB 00,10,11,01
  int walk_phase = 0;
  bit walk_up = 1'b1;

  function automatic line_filt_t settle_line(input logic raw, input line_filt_t cur);
    logic [FLT_W-1:0] need;
    line_filt_t nxt;
    need = (flt_reg == '0) ? FLT_W'(1) : flt_reg;
    nxt = cur;
    if (raw == cur.level) begin
      nxt.run = '0;
    end else begin
      nxt.run = cur.run + FLT_W'(1);
      if (nxt.run >= need) begin
        nxt.level = raw;
        nxt.run = '0;
      end
    end
    return nxt;
  endfunction

  function automatic pos_result_t advance_counter(input sample_t s);
    logic [MAX_W-1:0] lim;
    logic [CNT_W-1:0] quot;
    logic old_a, old_b, moved_a, moved_b, up;
    pos_result_t r;
    lim = (lim_reg > qpc_pkg::POS_LIMIT) ? qpc_pkg::POS_LIMIT : lim_reg;
    if (s.cmd == CMD_LOAD) begin
      held_pos = s.load_value;
      edge_cnt = CNT_W'({s.load_value, 2'b00});
    end else begin
      old_a = filt_a.level;
      old_b = filt_b.level;
      filt_a = settle_line(s.line_a, filt_a);
      filt_b = settle_line(s.line_b, filt_b);
      moved_a = filt_a.level != old_a;
      moved_b = filt_b.level != old_b;
      // both lines moving at once is no valid step
      if (moved_a != moved_b) begin
        up = moved_a ? (filt_a.level != filt_b.level) : (filt_a.level == filt_b.level);
        if (up) begin
          edge_cnt = edge_cnt + CNT_W'(1);
          moving_down = 1'b0;
        end else begin
          edge_cnt = edge_cnt - CNT_W'(1);
          moving_down = 1'b1;
        end
      end
    end
    if (held_pos == '0 && moving_down) begin
      edge_cnt = '0;
    end else begin
      quot = edge_cnt >> 2;
      if (quot >= CNT_W'(lim)) begin
        held_pos = '0;
        edge_cnt = '0;
      end else begin
        held_pos = quot[POS_W-1:0];
      end
    end
    if (MAX_W'(held_pos) >= lim) begin
      held_pos = '0;
      edge_cnt = '0;
    end
    r.position = held_pos;
    r.changed = edge_cnt != last_cnt;
    r.counting_down = moving_down;
    last_cnt = edge_cnt;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) expected_q.push_back(advance_counter(drv_item));
      if (!(drv_valid && !in_ch.ready)) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          drv_item <= pending_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    pos_result_t got, want;
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (out_ch.valid && res_ready) begin
        got.position = out_ch.position;
        got.changed = out_ch.changed;
        got.counting_down = out_ch.counting_down;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: pos %0d chg %0b down %0b",
                     got.position, got.changed, got.counting_down);
        end else begin
          want = expected_q.pop_front();
          if (got.position !== want.position || got.changed !== want.changed ||
              got.counting_down !== want.counting_down) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: want pos %0d chg %0b down %0b, got pos %0d chg %0b down %0b",
                       want.position, want.changed, want.counting_down,
                       got.position, got.changed, got.counting_down);
          end
        end
      end
      res_ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  task automatic push_tick(input logic a, input logic b);
    sample_t s;
    s.cmd = CMD_TICK;
    s.line_a = a;
    s.line_b = b;
    s.load_value = POS_W'($urandom_range(POS_MAX));
    pending_q.push_back(s);
  endtask

  task automatic push_load(input logic [POS_W-1:0] v);
    sample_t s;
    s.cmd = CMD_LOAD;
    s.line_a = 1'($urandom_range(1));
    s.line_b = 1'($urandom_range(1));
    s.load_value = v;
    pending_q.push_back(s);
  endtask

  function automatic logic [POS_W-1:0] pick_load();
    int eff, r, v;
    eff = (lim_reg > qpc_pkg::POS_LIMIT) ? int'(qpc_pkg::POS_LIMIT) : int'(lim_reg);
    r = $urandom_range(99);
    if (r < 30) begin
      v = $urandom_range(POS_MAX);
    end else if (r < 55) begin
      // around the wrap point
      v = eff - int'($urandom_range(3));
      if (v < 0) v = 0;
      if (v > POS_MAX) v = POS_MAX;
    end else if (r < 70) begin
      v = POS_MAX;
    end else begin
      v = $urandom_range(20);
    end
    return POS_W'(v);
  endfunction

  task automatic feed_walk(input int n);
    int added, r, len, need;
    added = 0;
    while (added < n) begin
      need = (flt_reg == '0) ? 1 : int'(flt_reg);
      r = $urandom_range(99);
      if (r < 5) begin
        push_load(pick_load());
        added++;
      end else if (r < 15) begin
        // bounce: short bursts of random levels
        len = $urandom_range(need > 1 ? need - 1 : 1, 1);
        repeat (len) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        added += len;
      end else begin
        if (r < 19) begin
          walk_phase = (walk_phase + 2) % 4;
        end else begin
          if ($urandom_range(99) < 20) walk_up = !walk_up;
          walk_phase = walk_up ? (walk_phase + 1) % 4 : (walk_phase + 3) % 4;
        end
        len = need + $urandom_range(2);
        repeat (len) push_tick(walk_phase == 1 || walk_phase == 2, walk_phase >= 2);
        added += len;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || drv_valid || expected_q.size() != 0) @(posedge clk);
    // result path is two deep; let it settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [MAX_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == qpc_pkg::CFG_MAX_VALUE) lim_reg = val;
    else if (idx == qpc_pkg::CFG_FILTER_LENGTH) flt_reg = val[FLT_W-1:0];
  endtask

  task automatic configure(input logic [MAX_W-1:0] mv, input int fl, input bit calm);
    wait_idle();
    write_reg(qpc_pkg::CFG_MAX_VALUE, mv);
    write_reg(qpc_pkg::CFG_FILTER_LENGTH, MAX_W'(fl));
    steady = calm;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: a load at the top and two alternating bit patterns, then both lines flipping together
    push_load(POS_W'(POS_MAX));
    push_load(POS_W'(14'h2AAA));
    push_load(POS_W'(14'h1555));
    repeat (8) push_tick(1'b1, 1'b1);
    walk_phase = 2;
    feed_walk(120);

    // zero filter, tiny limit: down at zero stays pinned, up runs into the wrap
    configure(15'd2, 0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_load('0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    repeat (2) begin
      push_tick(1'b1, 1'b0);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);
    end
    walk_phase = 0;
    feed_walk(140);

    configure(qpc_pkg::POS_LIMIT, 1, 1'b1);
    feed_walk(300);
    configure(15'd0, 2, 1'b0);
    feed_walk(80);
    configure(15'h7FFF, 15, 1'b0);
    feed_walk(150);
    configure(15'd1, 1, 1'b0);
    feed_walk(100);
    configure(15'd100, 3, 1'b0);
    feed_walk(200);
    configure(qpc_pkg::POS_LIMIT, 4, 1'b0);
    feed_walk(200);

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
